FILE: hdl/xtea_pkg.sv
// Shared types and constants for the XTEA block cipher.
// No dependencies; used by the channel interfaces, the round cell and the top level.
`default_nettype none

package xtea_pkg;

   localparam int unsigned ROUNDS   = 32;
   localparam int unsigned STAGES   = 2 * ROUNDS;   // one half-round per cell
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [WORD_W-1:0] DELTA   = 32'h9E37_79B9;
   // starting sum for decryption: DELTA * ROUNDS, wrapped to 32 bits
   localparam logic [WORD_W-1:0] DEC_SUM = 32'(64'(DELTA) * 64'(ROUNDS));

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOADED = 3'd4;

   // command codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef logic [3:0][WORD_W-1:0] key_type;

   // block in flight through the round chain
   typedef struct packed {
      logic              dec;     // 1: decrypt
      logic              phase;   // which half of the XTEA cycle comes next
      logic              status;  // 1: key not loaded, pass through
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
   } token_type;

endpackage

`default_nettype wire

FILE: hdl/xtea_req_if.sv
// Request channel: command and one 64-bit block as two words.
// Depends on xtea_pkg.
`default_nettype none

interface xtea_req_if;
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [xtea_pkg::WORD_W-1:0]    block_word0;
   logic [xtea_pkg::WORD_W-1:0]    block_word1;

   modport source (output valid, output command, output block_word0, output block_word1,
                   input ready);
   modport sink   (input valid, input command, input block_word0, input block_word1,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/xtea_rsp_if.sv
// Response channel: processed block and status.
// Depends on xtea_pkg.
`default_nettype none

interface xtea_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [xtea_pkg::WORD_W-1:0]    out_word0;
   logic [xtea_pkg::WORD_W-1:0]    out_word1;
   logic                           status;

   modport source (output valid, output out_word0, output out_word1, output status,
                   input ready);
   modport sink   (input valid, input out_word0, input out_word1, input status,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/xtea_cell.sv
// One XTEA half-round cell of the round chain, with its pipeline register.
// Depends on xtea_pkg.
`default_nettype none

module xtea_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire xtea_pkg::key_type    key,
   input  wire logic                 in_vld,
   input  wire xtea_pkg::token_type  in_tok,
   output      logic                 out_vld,
   output      xtea_pkg::token_type  out_tok
);

   logic                          vld_ff;
   xtea_pkg::token_type           tok_ff;
   xtea_pkg::token_type           tok_in;
   logic                          use_hi;
   logic [xtea_pkg::WORD_W-1:0]   src;
   logic [xtea_pkg::WORD_W-1:0]   dst;
   logic [1:0]                    kidx;
   logic [xtea_pkg::WORD_W-1:0]   mixv;
   logic [xtea_pkg::WORD_W-1:0]   fval;
   logic [xtea_pkg::WORD_W-1:0]   new_dst;

   // enc phase 0 / dec phase 1 update v0 from v1 with key[sum[1:0]];
   // the other two update v1 from v0 with key[sum[12:11]]
   always_comb begin
      use_hi  = in_tok.phase ^ in_tok.dec;
      src     = use_hi ? in_tok.v0 : in_tok.v1;
      dst     = use_hi ? in_tok.v1 : in_tok.v0;
      kidx    = use_hi ? in_tok.sum[12:11] : in_tok.sum[1:0];
      mixv    = ((src << 4) ^ (src >> 5)) + src;
      fval    = mixv ^ (in_tok.sum + key[kidx]);
      new_dst = (in_tok.dec == xtea_pkg::CMD_DECRYPT) ? dst - fval : dst + fval;

      tok_in       = in_tok;
      tok_in.phase = ~in_tok.phase;
      if (!in_tok.status) begin
         if (use_hi) begin
            tok_in.v1 = new_dst;
         end else begin
            tok_in.v0 = new_dst;
         end
         if (!in_tok.phase) begin
            tok_in.sum = (in_tok.dec == xtea_pkg::CMD_DECRYPT) ?
                         in_tok.sum - xtea_pkg::DELTA : in_tok.sum + xtea_pkg::DELTA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign out_vld = vld_ff;
   assign out_tok = tok_ff;

endmodule

`default_nettype wire

FILE: hdl/xtea_block_cipher.sv
// XTEA block cipher top level: key registers and the chain of round cells.
// Depends on xtea_pkg, xtea_req_if, xtea_rsp_if and xtea_cell.
//
// Usage:
//  - csr_*: plain write port. Indexes 0..3 load the key words, index 4 sets
//    key_loaded (bit 0). Other indexes are ignored. Write only while idle.
//  - req_if: one transfer per block: command (0 encrypt, 1 decrypt) and the
//    two block words. rsp_if: one transfer per block, in order, with the
//    result words and status (0 ok, 1 key not loaded, data passed through).
//  - Chain: each cell of the chain does one half-round and registers it;
//    a block passes every cell in order from request to response valid.
//  - Throughput: one block per cycle unless stalled; up to 2*ROUNDS in flight.
//  - Stall: the whole chain advances as one. While the response at the end
//    of the chain is valid and not taken, the chain holds and req_if.ready
//    is low; otherwise a new block can be taken every cycle.
//  - Reset: synchronous, clears the key, key_loaded and all valid bits.
`default_nettype none

module xtea_block_cipher (
   input  wire logic                              clock,
   input  wire logic                              reset,
   xtea_req_if.sink                               req_if,
   xtea_rsp_if.source                             rsp_if,
   input  wire logic                              csr_wr_en,
   input  wire logic [xtea_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [xtea_pkg::WORD_W-1:0]       csr_wdata
);

   xtea_pkg::key_type    key_ff;
   logic                 key_loaded_ff;
   logic                 adv;
   xtea_pkg::token_type  head_tok;

   logic                 vld_chain [xtea_pkg::STAGES+1];
   xtea_pkg::token_type  tok_chain [xtea_pkg::STAGES+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         key_loaded_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            xtea_pkg::CSR_KEY_WORD0:  key_ff[0]     <= csr_wdata;
            xtea_pkg::CSR_KEY_WORD1:  key_ff[1]     <= csr_wdata;
            xtea_pkg::CSR_KEY_WORD2:  key_ff[2]     <= csr_wdata;
            xtea_pkg::CSR_KEY_WORD3:  key_ff[3]     <= csr_wdata;
            xtea_pkg::CSR_KEY_LOADED: key_loaded_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // whole chain moves when the last stage is empty or being taken
   assign adv          = ~vld_chain[xtea_pkg::STAGES] | rsp_if.ready;
   assign req_if.ready = adv;

   always_comb begin
      head_tok.dec    = req_if.command;
      head_tok.phase  = 1'b0;
      head_tok.status = ~key_loaded_ff;
      head_tok.sum    = (req_if.command == xtea_pkg::CMD_DECRYPT) ? xtea_pkg::DEC_SUM : '0;
      head_tok.v0     = req_if.block_word0;
      head_tok.v1     = req_if.block_word1;
   end

   assign vld_chain[0] = req_if.valid;
   assign tok_chain[0] = head_tok;

   for (genvar i = 0; i < xtea_pkg::STAGES; i++) begin : g_cell
      xtea_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .key     (key_ff),
         .in_vld  (vld_chain[i]),
         .in_tok  (tok_chain[i]),
         .out_vld (vld_chain[i+1]),
         .out_tok (tok_chain[i+1])
      );
   end

   // last cell register is the response register
   assign rsp_if.valid     = vld_chain[xtea_pkg::STAGES];
   assign rsp_if.out_word0 = tok_chain[xtea_pkg::STAGES].v0;
   assign rsp_if.out_word1 = tok_chain[xtea_pkg::STAGES].v1;
   assign rsp_if.status    = tok_chain[xtea_pkg::STAGES].status;

`ifndef SYNTHESIS
   // nothing comes out of the chain right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

   // every block has seen an even number of half-rounds
   a_phase_done: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !tok_chain[xtea_pkg::STAGES].phase)
      else $error("block left chain mid-cycle");

   // a keyed encrypt ends at DELTA*ROUNDS, a keyed decrypt back at zero
   a_sum_enc: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.status &&
       tok_chain[xtea_pkg::STAGES].dec == xtea_pkg::CMD_ENCRYPT)
      |-> tok_chain[xtea_pkg::STAGES].sum == xtea_pkg::DEC_SUM)
      else $error("encrypt sum schedule broken");

   a_sum_dec: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.status &&
       tok_chain[xtea_pkg::STAGES].dec == xtea_pkg::CMD_DECRYPT)
      |-> tok_chain[xtea_pkg::STAGES].sum == '0)
      else $error("decrypt sum schedule broken");
`endif

endmodule

`default_nettype wire
